[hdl/ktmiu_pkg.sv]
// ----------------------------------------------------------------------------
// ktmiu_pkg
// shared types and constants of the key, timer and memory unit
// ----------------------------------------------------------------------------
package ktmiu_pkg;

    localparam int MEMORY_BYTES_DEFAULT = 4096;
    localparam int FONT_BASE_RESET      = 80;

    localparam logic [2:0] ACT_EXEC    = 3'd0;
    localparam logic [2:0] ACT_TICK    = 3'd1;
    localparam logic [2:0] ACT_WR_MEM  = 3'd2;
    localparam logic [2:0] ACT_WR_REG  = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    localparam logic [3:0] GRP_E = 4'hE;
    localparam logic [3:0] GRP_F = 4'hF;

    localparam logic [7:0] OP_SKP  = 8'h9E;
    localparam logic [7:0] OP_SKNP = 8'hA1;
    localparam logic [7:0] OP_GDT  = 8'h07;
    localparam logic [7:0] OP_SDT  = 8'h15;
    localparam logic [7:0] OP_SST  = 8'h18;
    localparam logic [7:0] OP_ADDI = 8'h1E;
    localparam logic [7:0] OP_WKEY = 8'h0A;
    localparam logic [7:0] OP_FONT = 8'h29;
    localparam logic [7:0] OP_BCD  = 8'h33;
    localparam logic [7:0] OP_STR  = 8'h55;
    localparam logic [7:0] OP_LDR  = 8'h65;

    localparam logic [1:0] PC_ADV  = 2'd0;
    localparam logic [1:0] PC_SKIP = 2'd1;
    localparam logic [1:0] PC_REP  = 2'd2;

    localparam logic CFG_ADV_MODE  = 1'b0;
    localparam logic CFG_FONT_BASE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_BCD,
        ST_STORE,
        ST_LOAD_ADDR,
        ST_LOAD_WAIT,
        ST_LOAD_WR,
        ST_READ_WAIT,
        ST_FINISH,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       capture;     // latch input beat
        logic       exec_simple; // simple opcode effects, bcd digit capture
        logic       tick_step;   // one key of the latch scan
        logic       tick_end;    // timer decrement
        logic       mem_we;
        logic [1:0] mem_src;     // 0 input, 1 register, 2 bcd digit
        logic       mem_addr_off;// use index plus counter
        logic       mem_rd;
        logic       reg_load;    // write loaded byte into counter register
        logic       reg_wr_in;   // register write beat
        logic       cnt_clr;
        logic       cnt_inc;
        logic       idx_adv;
        logic       read_cap;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] grp;
        logic [7:0] low;
        logic [3:0] x;
        logic [3:0] cnt;
        logic       cnt_last;
    } status_t;

    localparam logic [1:0] MSRC_IN  = 2'd0;
    localparam logic [1:0] MSRC_REG = 2'd1;
    localparam logic [1:0] MSRC_BCD = 2'd2;

endpackage

[hdl/ktmiu_ram.sv]
// ----------------------------------------------------------------------------
// ktmiu_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module ktmiu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[hdl/ktmiu_ctrl.sv]
// ----------------------------------------------------------------------------
// ktmiu_ctrl
// sequencer for the unit: decodes the beat and steps the datapath
// ----------------------------------------------------------------------------
module ktmiu_ctrl
    import ktmiu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    input  logic    out_free,
    input  status_t sts,
    output logic    in_ready,
    output logic    out_valid_set,
    output cmd_t    cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.action)
                    ACT_TICK:   state_next = ST_TICK;
                    ACT_READ:   state_next = ST_READ_WAIT;
                    ACT_EXEC:
                    begin
                        if (sts.grp == GRP_F && sts.low == OP_BCD)
                        begin
                            state_next = ST_BCD;
                        end
                        else if (sts.grp == GRP_F && sts.low == OP_STR)
                        begin
                            state_next = ST_STORE;
                        end
                        else if (sts.grp == GRP_F && sts.low == OP_LDR)
                        begin
                            state_next = ST_LOAD_ADDR;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    default:    state_next = ST_OUT;
                endcase
            end
            ST_TICK:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BCD:
            begin
                if (sts.cnt == 4'd2)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_STORE:
            begin
                if (sts.cnt == sts.x)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LOAD_ADDR: state_next = ST_LOAD_WAIT;
            ST_LOAD_WAIT: state_next = ST_LOAD_WR;
            ST_LOAD_WR:
            begin
                state_next = (sts.cnt == sts.x) ? ST_FINISH : ST_LOAD_ADDR;
            end
            ST_READ_WAIT: state_next = ST_OUT;
            ST_FINISH:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid_set = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_fire;
            end
            ST_DECODE:
            begin
                cmd.cnt_clr = 1'b1;
                if (sts.action == ACT_EXEC)
                begin
                    cmd.exec_simple = 1'b1;
                end
                if (sts.action == ACT_WR_MEM)
                begin
                    cmd.mem_we  = 1'b1;
                    cmd.mem_src = MSRC_IN;
                end
                if (sts.action == ACT_WR_REG)
                begin
                    cmd.reg_wr_in = 1'b1;
                end
                if (sts.action == ACT_READ)
                begin
                    cmd.mem_rd = 1'b1;
                end
            end
            ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                cmd.cnt_inc   = 1'b1;
            end
            ST_BCD:
            begin
                cmd.mem_we       = 1'b1;
                cmd.mem_src      = MSRC_BCD;
                cmd.mem_addr_off = 1'b1;
                cmd.cnt_inc      = 1'b1;
            end
            ST_STORE:
            begin
                cmd.mem_we       = 1'b1;
                cmd.mem_src      = MSRC_REG;
                cmd.mem_addr_off = 1'b1;
                cmd.cnt_inc      = 1'b1;
            end
            ST_LOAD_ADDR:
            begin
                cmd.mem_rd       = 1'b1;
                cmd.mem_addr_off = 1'b1;
            end
            ST_LOAD_WAIT:
            begin
                cmd.mem_addr_off = 1'b1;
            end
            ST_LOAD_WR:
            begin
                cmd.reg_load = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_READ_WAIT:
            begin
                cmd.read_cap = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.tick_end = (sts.action == ACT_TICK);
                cmd.idx_adv  = (sts.action == ACT_EXEC);
            end
            ST_OUT:
            begin
                cmd.out_load  = out_free;
                out_valid_set = out_free;
            end
            default:
            begin
            end
        endcase
    end
endmodule

[hdl/ktmiu_dp.sv]
// ----------------------------------------------------------------------------
// ktmiu_dp
// datapath: registers, timers, key latch, index and the memory port
// ----------------------------------------------------------------------------
module ktmiu_dp
    import ktmiu_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [2:0]  in_action,
    input  logic [15:0] in_opcode,
    input  logic [15:0] in_key_mask,
    input  logic [11:0] in_address,
    input  logic [7:0]  in_write_data,
    input  logic        cfg_adv_mode,
    input  logic [11:0] cfg_font_base,
    output status_t     sts,
    output logic [1:0]  pc_effect,
    output logic [7:0]  register_value,
    output logic [7:0]  memory_value,
    output logic [15:0] index_value,
    output logic [7:0]  delay_value,
    output logic [7:0]  sound_value
);
    localparam int AW = $clog2(MEMORY_BYTES);

    logic [2:0]  action_reg;
    logic [15:0] opcode_reg;
    logic [15:0] mask_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wdata_reg;

    logic [7:0]  gpr_reg [16];
    logic [15:0] index_reg;
    logic [7:0]  delay_reg, sound_reg;
    logic [15:0] held_reg;
    logic [3:0]  latched_reg;
    logic        press_reg, release_reg;
    logic [3:0]  cnt_reg;
    logic [1:0]  pc_reg;
    logic [7:0]  rdreg_reg, rdmem_reg;
    logic [7:0]  bcd_h_reg, bcd_t_reg, bcd_o_reg;

    logic [3:0]  x;
    logic [7:0]  vx, low;
    logic [3:0]  grp;
    logic        held_vx;

    assign x   = opcode_reg[11:8];
    assign low = opcode_reg[7:0];
    assign grp = opcode_reg[15:12];
    assign vx  = gpr_reg[x];
    assign held_vx = held_reg[vx[3:0]];

    assign sts.action   = action_reg;
    assign sts.grp      = grp;
    assign sts.low      = low;
    assign sts.x        = x;
    assign sts.cnt      = cnt_reg;
    assign sts.cnt_last = (cnt_reg == 4'hF);

    // bcd digits of vx: hundreds by constant compares, tens by multiply by 205 and shift
    logic [7:0] h_d, t_d, o_d, rem;
    always_comb
    begin
        if (vx >= 8'd200)
        begin
            h_d = 8'd2;
            rem = vx - 8'd200;
        end
        else if (vx >= 8'd100)
        begin
            h_d = 8'd1;
            rem = vx - 8'd100;
        end
        else
        begin
            h_d = 8'd0;
            rem = vx;
        end
        t_d = 8'((16'(rem) * 16'd205) >> 11);
        o_d = rem - 8'(t_d * 8'd10);
    end

    // memory port
    logic [15:0]   off_addr;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic [7:0]    bcd_byte;

    assign off_addr = index_reg + {12'd0, cnt_reg};
    assign mem_addr = cmd.mem_addr_off ? off_addr[AW-1:0] : AW'(addr_reg);
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    bcd_byte = bcd_h_reg;
            2'd1:    bcd_byte = bcd_t_reg;
            default: bcd_byte = bcd_o_reg;
        endcase
        case (cmd.mem_src)
            MSRC_REG: mem_wdata = gpr_reg[cnt_reg];
            MSRC_BCD: mem_wdata = bcd_byte;
            default:  mem_wdata = wdata_reg;
        endcase
    end

    ktmiu_ram #(
        .WIDTH (8),
        .DEPTH (MEMORY_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (cmd.mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            opcode_reg <= in_opcode;
            mask_reg   <= in_key_mask;
            addr_reg   <= in_address;
            wdata_reg  <= in_write_data;
        end
        if (cmd.exec_simple)
        begin
            bcd_h_reg <= h_d;
            bcd_t_reg <= t_d;
            bcd_o_reg <= o_d;
        end
        if (cmd.read_cap)
        begin
            rdmem_reg <= mem_rdata;
        end
    end

    // key scan step for key cnt
    logic [15:0] held_step;
    logic        press_a, release_a;
    logic [3:0]  latched_a;
    always_comb
    begin
        held_step = held_reg;
        held_step[cnt_reg] = mask_reg[cnt_reg];
        press_a   = press_reg;
        release_a = release_reg;
        latched_a = latched_reg;
        if (cnt_reg == 4'd0)
        begin
            release_a = 1'b0;
        end
        if (held_step[cnt_reg] && !press_a)
        begin
            press_a   = 1'b1;
            latched_a = cnt_reg;
            release_a = 1'b0;
        end
        if (press_a && !held_step[latched_a] && !release_a)
        begin
            release_a = 1'b1;
            press_a   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                gpr_reg[i] <= 8'd0;
            end
            index_reg   <= 16'd0;
            delay_reg   <= 8'd0;
            sound_reg   <= 8'd0;
            held_reg    <= 16'd0;
            latched_reg <= 4'd0;
            press_reg   <= 1'b0;
            release_reg <= 1'b0;
            cnt_reg     <= 4'd0;
            pc_reg      <= PC_ADV;
            rdreg_reg   <= 8'd0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= 4'd0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (cmd.reg_wr_in)
            begin
                gpr_reg[addr_reg[3:0]] <= wdata_reg;
            end
            if (cmd.reg_load)
            begin
                gpr_reg[cnt_reg] <= mem_rdata;
            end
            if (cmd.tick_step)
            begin
                held_reg    <= held_step;
                press_reg   <= press_a;
                release_reg <= release_a;
                latched_reg <= latched_a;
            end
            if (cmd.tick_end)
            begin
                if (delay_reg != 8'd0)
                begin
                    delay_reg <= delay_reg - 8'd1;
                end
                if (sound_reg != 8'd0)
                begin
                    sound_reg <= sound_reg - 8'd1;
                end
            end
            if (cmd.idx_adv && cfg_adv_mode && grp == GRP_F
                && (low == OP_STR || low == OP_LDR))
            begin
                index_reg <= index_reg + {12'd0, x} + 16'd1;
            end
            if (cmd.exec_simple)
            begin
                pc_reg <= PC_ADV;
                if (grp == GRP_E)
                begin
                    if ((low == OP_SKP && held_vx) || (low == OP_SKNP && !held_vx))
                    begin
                        pc_reg <= PC_SKIP;
                    end
                end
                else if (grp == GRP_F)
                begin
                    case (low)
                        OP_GDT:  gpr_reg[x] <= delay_reg;
                        OP_SDT:  delay_reg <= vx;
                        OP_SST:  sound_reg <= vx;
                        OP_ADDI: index_reg <= index_reg + {8'd0, vx};
                        OP_WKEY:
                        begin
                            if (!release_reg)
                            begin
                                pc_reg <= PC_REP;
                            end
                            else
                            begin
                                gpr_reg[x] <= {4'd0, latched_reg};
                            end
                        end
                        OP_FONT:
                        begin
                            index_reg <= {4'd0, cfg_font_base}
                                + {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (cmd.capture)
            begin
                pc_reg <= PC_ADV;
            end
            if (cmd.mem_rd && !cmd.mem_addr_off)
            begin
                rdreg_reg <= gpr_reg[addr_reg[3:0]];
            end
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pc_effect      <= pc_reg;
            register_value <= (action_reg == ACT_EXEC) ? vx :
                              (action_reg == ACT_READ) ? rdreg_reg : 8'd0;
            memory_value   <= (action_reg == ACT_READ) ? rdmem_reg : 8'd0;
            index_value    <= index_reg;
            delay_value    <= delay_reg;
            sound_value    <= sound_reg;
        end
    end
endmodule

[hdl/key_timer_memory_instruction_unit.sv]
// ----------------------------------------------------------------------------
// key_timer_memory_instruction_unit
// executes the key, timer and memory opcode groups of a small virtual cpu
// ----------------------------------------------------------------------------
// latency from accepted beat to result valid depends on the item: a simple item
// is decoded, a bcd store writes its three digits, a frame tick runs the 16-step
// key scan, a block store writes one byte per step and a block load reads each
// byte through the address, wait and register write states; one item at a time,
// the next beat is taken once the result is registered, with the result held until taken
// reset: rst_n asynchronous, clears registers, timers, key latch and index;
// memory contents are undefined until written
module key_timer_memory_instruction_unit
    import ktmiu_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], opcode[18:3], key_mask[34:19], address[46:35],
    // write_data[54:47], zero fill [55]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pc_effect[1:0], register_value[9:2], memory_value[17:10],
    // index_value[33:18], delay_value[41:34], sound_value[49:42], fill [55:50]
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    status_t sts;
    cmd_t    cmd;
    logic    in_fire, out_free, out_valid_set;
    logic    out_valid_reg;
    logic    adv_mode_reg;
    logic [11:0] font_base_reg;
    logic [1:0]  pc_effect;
    logic [7:0]  register_value, memory_value, delay_value, sound_value;
    logic [15:0] index_value;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            adv_mode_reg  <= 1'b0;
            font_base_reg <= 12'(FONT_BASE_RESET);
        end
        else
        begin
            if (out_valid_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index[0])
                    CFG_ADV_MODE:  adv_mode_reg  <= cfg_data[0];
                    CFG_FONT_BASE: font_base_reg <= cfg_data;
                    default:       adv_mode_reg  <= adv_mode_reg;
                endcase
            end
        end
    end

    ktmiu_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .out_free      (out_free),
        .sts           (sts),
        .in_ready      (s_axis_tready),
        .out_valid_set (out_valid_set),
        .cmd           (cmd)
    );

    ktmiu_dp #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_action      (s_axis_tdata[2:0]),
        .in_opcode      (s_axis_tdata[18:3]),
        .in_key_mask    (s_axis_tdata[34:19]),
        .in_address     (s_axis_tdata[46:35]),
        .in_write_data  (s_axis_tdata[54:47]),
        .cfg_adv_mode   (adv_mode_reg),
        .cfg_font_base  (font_base_reg),
        .sts            (sts),
        .pc_effect      (pc_effect),
        .register_value (register_value),
        .memory_value   (memory_value),
        .index_value    (index_value),
        .delay_value    (delay_value),
        .sound_value    (sound_value)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, sound_value, delay_value, index_value,
                            memory_value, register_value, pc_effect};
endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives random and directed beats into the key, timer and memory unit and
// checks every result against a cycle-free model of the instruction set
// ----------------------------------------------------------------------------
module tb_top;
    import ktmiu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES = 4096;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0]  sound;
        logic [7:0]  delay;
        logic [15:0] index;
        logic [7:0]  mem;
        logic [7:0]  rv;
        logic [1:0]  pc;
    } result_t;

    class result_board;
        result_t pending[$];
        int errors;
        function new();
            errors = 0;
        endfunction
        function void note(result_t r);
            pending.push_back(r);
        endfunction
        function void check(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected pc %0d reg %h mem %h idx %h dt %h st %h,",
                              " got pc %0d reg %h mem %h idx %h dt %h st %h"},
                             want.pc, want.rv, want.mem, want.index, want.delay, want.sound,
                             got.pc, got.rv, got.mem, got.index, got.delay, got.sound);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [11:0] cfg_data;

    key_timer_memory_instruction_unit dut (.*);

    // model state
    logic [7:0]  m_regs [16];
    logic [7:0]  m_mem [MEM_BYTES];
    bit          m_written [MEM_BYTES];
    logic [15:0] m_index;
    logic [7:0]  m_dt, m_st;
    logic [15:0] m_held;
    logic [3:0]  m_latch;
    logic        m_press, m_rel;
    logic        m_adv;
    logic [11:0] m_font;

    result_board board;
    int  cycles;
    bit  calm;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata[49:0]);
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
    end

    function automatic int waddr(int a);
        return a % MEM_BYTES;
    endfunction

    function automatic void scan_keys(logic [15:0] mask);
        m_rel = 0;
        for (int i = 0; i < 16; i++) begin
            m_held[i] = mask[i];
            if (m_held[i] && !m_press) begin
                m_press = 1;
                m_latch = 4'(i);
                m_rel = 0;
            end
            if (m_press && !m_held[m_latch] && !m_rel) begin
                m_rel = 1;
                m_press = 0;
            end
        end
        if (m_dt != 0) m_dt--;
        if (m_st != 0) m_st--;
    endfunction

    function automatic logic [1:0] run_opcode(logic [15:0] op);
        logic [3:0] x;
        logic [7:0] vx;
        x = op[11:8];
        vx = m_regs[x];
        if (op[15:12] == GRP_E) begin
            if (op[7:0] == OP_SKP && m_held[vx[3:0]]) return PC_SKIP;
            if (op[7:0] == OP_SKNP && !m_held[vx[3:0]]) return PC_SKIP;
            return PC_ADV;
        end
        if (op[15:12] != GRP_F) return PC_ADV;
        case (op[7:0])
            OP_GDT:  m_regs[x] = m_dt;
            OP_SDT:  m_dt = vx;
            OP_SST:  m_st = vx;
            OP_ADDI: m_index = m_index + {8'd0, vx};
            OP_WKEY: begin
                if (!m_rel) return PC_REP;
                m_regs[x] = {4'd0, m_latch};
            end
            OP_FONT: m_index = 16'(m_font) + 16'(vx[3:0]) * 16'd5;
            OP_BCD: begin
                m_mem[waddr(m_index + 2)] = 8'(vx % 8'd10);
                m_mem[waddr(m_index + 1)] = 8'((vx / 8'd10) % 8'd10);
                m_mem[waddr(m_index)] = 8'(vx / 8'd100);
                for (int i = 0; i < 3; i++) m_written[waddr(m_index + i)] = 1;
            end
            OP_STR: begin
                for (int i = 0; i <= x; i++) begin
                    m_mem[waddr(m_index + i)] = m_regs[i];
                    m_written[waddr(m_index + i)] = 1;
                end
                if (m_adv) m_index = 16'(m_index + x + 1);
            end
            OP_LDR: begin
                for (int i = 0; i <= x; i++) m_regs[i] = m_mem[waddr(m_index + i)];
                if (m_adv) m_index = 16'(m_index + x + 1);
            end
            default: ;
        endcase
        return PC_ADV;
    endfunction

    function automatic result_t predict_step(logic [2:0] act, logic [15:0] op,
                                             logic [15:0] mask, logic [11:0] addr,
                                             logic [7:0] data);
        result_t r;
        r = '0;
        case (act)
            ACT_EXEC: begin
                r.pc = run_opcode(op);
                r.rv = m_regs[op[11:8]];
            end
            ACT_TICK: scan_keys(mask);
            ACT_WR_MEM: begin
                m_mem[waddr(addr)] = data;
                m_written[waddr(addr)] = 1;
            end
            ACT_WR_REG: m_regs[addr[3:0]] = data;
            ACT_READ: begin
                r.rv = m_regs[addr[3:0]];
                r.mem = m_mem[waddr(addr)];
            end
            default: ;
        endcase
        r.index = m_index;
        r.delay = m_dt;
        r.sound = m_st;
        return r;
    endfunction

    // true if a read or block load would read a byte never written
    function automatic bit reads_unwritten(logic [2:0] act, logic [15:0] op,
                                           logic [11:0] addr);
        if (act == ACT_READ) return !m_written[waddr(addr)];
        if (act == ACT_EXEC && op[15:12] == GRP_F && op[7:0] == OP_LDR)
            for (int i = 0; i <= op[11:8]; i++)
                if (!m_written[waddr(m_index + i)]) return 1;
        return 0;
    endfunction

    // the unit is busy after a beat, so waiting on the clock before raising valid
    // costs nothing and keeps the valid drop and raise apart
    task automatic send_beat(logic [2:0] act, logic [15:0] op, logic [15:0] mask,
                             logic [11:0] addr, logic [7:0] data);
        if (reads_unwritten(act, op, addr)) return;
        @(posedge clk);
        while (!calm && $urandom_range(0, 99) < 16) @(posedge clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, data, addr, mask, op, act};
        board.note(predict_step(act, op, mask, addr, data));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [11:0] val);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        if (idx == CFG_ADV_MODE) m_adv = val[0];
        else m_font = val;
    endtask

    task automatic random_beat();
        int pick;
        logic [15:0] op;
        logic [11:0] addr;
        logic [15:0] mask;
        pick = $urandom_range(0, 99);
        op = 16'($urandom);
        addr = 12'($urandom_range(0, 15));
        if (pick < 3) begin
            send_beat(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                      12'($urandom), 8'($urandom));
            return;
        end
        if (pick < 20) begin
            // mostly sparse masks so press then release sequences form
            if ($urandom_range(0, 2) == 0) mask = 16'($urandom);
            else if ($urandom_range(0, 1) == 0) mask = 16'h0;
            else mask = 16'h1 << $urandom_range(0, 15);
            send_beat(ACT_TICK, 0, mask, 0, 0);
            return;
        end
        if (pick < 32) begin
            addr = 12'($urandom);
            send_beat(ACT_WR_MEM, 0, 0, addr, 8'($urandom));
            return;
        end
        if (pick < 44) begin
            send_beat(ACT_WR_REG, 0, 0, 12'($urandom), 8'($urandom));
            return;
        end
        if (pick < 52) begin
            if ($urandom_range(0, 1) == 0) addr = m_index[11:0];
            else addr = 12'($urandom);
            send_beat(ACT_READ, 0, 0, addr, 0);
            return;
        end
        if (pick < 60) op[15:12] = GRP_E;
        else if (pick < 95) op[15:12] = GRP_F;
        case ($urandom_range(0, 12))
            0: op[7:0] = OP_SKP;
            1: op[7:0] = OP_SKNP;
            2: op[7:0] = OP_GDT;
            3: op[7:0] = OP_SDT;
            4: op[7:0] = OP_SST;
            5: op[7:0] = OP_ADDI;
            6: op[7:0] = OP_WKEY;
            7: op[7:0] = OP_FONT;
            8: op[7:0] = OP_BCD;
            9: op[7:0] = OP_STR;
            10: op[7:0] = OP_LDR;
            default: ;
        endcase
        // block loads rely on earlier stores, so store first at random
        if (op[7:0] == OP_LDR && $urandom_range(0, 1) == 0)
            send_beat(ACT_EXEC, {GRP_F, op[11:8], OP_STR}, 0, 0, 0);
        send_beat(ACT_EXEC, op, 0, 0, 0);
    endtask

    initial begin
        board = new();
        cycles = 0;
        calm = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (m_regs[i]) m_regs[i] = 0;
        foreach (m_mem[i]) begin
            m_mem[i] = 0;
            m_written[i] = 0;
        end
        m_index = 0; m_dt = 0; m_st = 0; m_held = 0; m_latch = 0;
        m_press = 0; m_rel = 0; m_adv = 0; m_font = 12'(FONT_BASE_RESET);
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every opcode, wait for key, wrap of index
        send_beat(ACT_EXEC, {GRP_F, 4'h0, OP_WKEY}, 0, 0, 0);
        send_beat(ACT_WR_REG, 0, 0, 12'hFFF, 8'hFF);
        send_beat(ACT_WR_REG, 0, 0, 12'h000, 8'hC8);
        send_beat(ACT_EXEC, {GRP_F, 4'hF, OP_SDT}, 0, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'hF, OP_SST}, 0, 0, 0);
        send_beat(ACT_TICK, 0, 16'h8000, 0, 0);
        send_beat(ACT_EXEC, {GRP_E, 4'hF, OP_SKP}, 0, 0, 0);
        send_beat(ACT_EXEC, {GRP_E, 4'h0, OP_SKNP}, 0, 0, 0);
        send_beat(ACT_TICK, 0, 16'h0000, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'h3, OP_WKEY}, 0, 0, 0);
        send_beat(ACT_TICK, 0, 16'hFFFF, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'h2, OP_GDT}, 0, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'hF, OP_FONT}, 0, 0, 0);
        for (int i = 0; i < 240; i++) send_beat(ACT_EXEC, {GRP_F, 4'hF, OP_ADDI}, 0, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'h0, OP_BCD}, 0, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'hF, OP_STR}, 0, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'hF, OP_LDR}, 0, 0, 0);
        send_beat(ACT_READ, 0, 0, 12'hFFF, 0);
        send_beat(ACT_WR_MEM, 0, 0, 12'hFFF, 8'hA5);
        send_beat(ACT_READ, 0, 0, 12'hFFF, 0);
        send_beat(ACT_EXEC, 16'h1234, 0, 0, 0);
        send_beat(ACT_EXEC, {GRP_F, 4'h1, 8'hFF}, 0, 0, 0);
        send_beat(3'd7, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_reg(CFG_ADV_MODE, 1);
                1: write_reg(CFG_FONT_BASE, 12'hFFF);
                2: write_reg(CFG_FONT_BASE, 12'h000);
                3: write_reg(CFG_ADV_MODE, 0);
                4: write_reg(CFG_FONT_BASE, 12'($urandom));
                default: write_reg(CFG_ADV_MODE, 1);
            endcase
            calm = (phase == 2);
            for (int n = 0; n < 230; n++) random_beat();
            calm = 0;
        end

        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

[files.f]
hdl/ktmiu_pkg.sv
hdl/ktmiu_ram.sv
hdl/ktmiu_ctrl.sv
hdl/ktmiu_dp.sv
hdl/key_timer_memory_instruction_unit.sv
verif/tb_top.sv
